// File: hdl/fcr_pkg.sv
`default_nettype none

package fcr_pkg;

  // field widths
  localparam int ModeW     = 2;
  localparam int NeuronW   = 6;
  localparam int ElemW     = 10;
  localparam int ValueW    = 32;
  localparam int WeightW   = 16;
  localparam int BiasW     = 32;
  localparam int ProdW     = 32;
  localparam int ActW      = 31;
  localparam int InCountW  = 11;
  localparam int OutCountW = 7;

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IN_COUNT  = 4'd0,
    CFG_OUT_COUNT = 4'd1
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD_WEIGHT = 2'd0,
    MODE_LOAD_BIAS   = 2'd1,
    MODE_LOAD_INPUT  = 2'd2,
    MODE_COMPUTE     = 2'd3
  } mode_e;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BIAS  = 5'b00010,
    S_MAC   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// File: hdl/fcr_ram.sv
`default_nettype none

module fcr_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/fully_connected_relu_layer.sv
`default_nettype none
// load items (weight, bias, input element) go straight to ram
// compute item: per neuron a bias fetch, in_count shared multiply-accumulate steps, a drain
//   until the read and product pipeline is empty and a result step, for each of out_count neurons
// in_stall_o high all run long, also while a result waits on out_stall_i;
//   zero neurons give no stall at all
// reset clears the sequencer, output valid and both counts (to 1); stores hold garbage until written

module fully_connected_relu_layer #(
  parameter int MAX_OUTPUTS = 64,
  parameter int MAX_INPUTS  = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fcr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fcr_pkg::CfgDataW-1:0]  cfg_data_i,
  // item channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fcr_pkg::ModeW-1:0]     mode_i,
  input  wire logic [fcr_pkg::NeuronW-1:0]   neuron_index_i,
  input  wire logic [fcr_pkg::ElemW-1:0]     element_index_i,
  input  wire logic signed [fcr_pkg::ValueW-1:0] value_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [fcr_pkg::NeuronW-1:0]        neuron_o,
  output logic [fcr_pkg::ActW-1:0]           activation_o,
  output logic                               last_o
);

  // address widths of the three stores
  localparam int NW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int EW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int WD  = MAX_OUTPUTS * MAX_INPUTS;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
  // counter widths, wide enough to hold the maximum count itself
  localparam int NCW = $clog2(MAX_OUTPUTS + 1);
  localparam int ECW = $clog2(MAX_INPUTS + 1);
  // exact accumulator: bias plus up to MAX_INPUTS products of magnitude 2^30
  localparam int AW  = fcr_pkg::BiasW + 1 + EW;

  // configuration registers
  logic [fcr_pkg::InCountW-1:0]  in_count_q;
  logic [fcr_pkg::OutCountW-1:0] out_count_q;

  // sequencer
  fcr_pkg::state_e state_q, state_d;
  logic [NCW-1:0] neuron_q, neuron_d;
  logic [NCW-1:0] nout_q, nout_d;
  logic [ECW-1:0] elem_q, elem_d;
  logic [ECW-1:0] nin_q, nin_d;
  logic [WAW-1:0] wbase_q, wbase_d;
  logic [WAW-1:0] waddr_q, waddr_d;

  // pipeline flags: bias read in flight, weight/input read in flight, product ready
  logic bias_vld_q, rd_vld_q, prod_vld_q;

  // datapath
  logic signed [fcr_pkg::ProdW-1:0] prod_q;
  logic signed [AW-1:0]             acc_q;
  logic [fcr_pkg::ActW-1:0]         act_sat;

  // output register
  logic                       out_valid_q;
  logic [fcr_pkg::NeuronW-1:0] out_neuron_q;
  logic [fcr_pkg::ActW-1:0]   out_act_q;
  logic                       out_last_q;

  // ram ports
  logic                        w_we, b_we, x_we;
  logic [WAW-1:0]              w_waddr;
  logic [NW-1:0]               b_waddr;
  logic [EW-1:0]               x_waddr;
  logic [fcr_pkg::WeightW-1:0] w_rdata, x_rdata;
  logic [fcr_pkg::BiasW-1:0]   b_rdata;
  logic                        mac_rd, bias_rd;

  logic           in_xfer, out_load, run_last;
  logic [ECW-1:0] nin_clamp;
  logic [NCW-1:0] nout_clamp;
  logic           ni_ok, ei_ok;
  fcr_pkg::mode_e mode;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= fcr_pkg::InCountW'(1);
      out_count_q <= fcr_pkg::OutCountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fcr_pkg::cfg_idx_e'(cfg_index_i))
        fcr_pkg::CFG_IN_COUNT:  in_count_q  <= cfg_data_i[fcr_pkg::InCountW-1:0];
        fcr_pkg::CFG_OUT_COUNT: out_count_q <= cfg_data_i[fcr_pkg::OutCountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != fcr_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign mode       = fcr_pkg::mode_e'(mode_i);

  // loads beyond the store size are dropped
  assign ni_ok = int'(neuron_index_i) < MAX_OUTPUTS;
  assign ei_ok = int'(element_index_i) < MAX_INPUTS;

  assign w_we = in_xfer && (mode == fcr_pkg::MODE_LOAD_WEIGHT) && ni_ok && ei_ok;
  assign b_we = in_xfer && (mode == fcr_pkg::MODE_LOAD_BIAS) && ni_ok;
  assign x_we = in_xfer && (mode == fcr_pkg::MODE_LOAD_INPUT) && ei_ok;

  // row-major weight layout, neuron times MAX_INPUTS plus element
  assign w_waddr = WAW'(32'(neuron_index_i) * 32'(MAX_INPUTS) + 32'(element_index_i));
  assign b_waddr = NW'(neuron_index_i);
  assign x_waddr = EW'(element_index_i);

  // counts above the store size saturate
  assign nin_clamp  = (int'(in_count_q) > MAX_INPUTS) ? ECW'(MAX_INPUTS) : ECW'(in_count_q);
  assign nout_clamp = (int'(out_count_q) > MAX_OUTPUTS) ? NCW'(MAX_OUTPUTS)
                                                        : NCW'(out_count_q);

  assign bias_rd  = (state_q == fcr_pkg::S_BIAS);
  assign mac_rd   = (state_q == fcr_pkg::S_MAC);
  assign run_last = ((neuron_q + NCW'(1)) == nout_q);
  assign out_load = (state_q == fcr_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  fcr_ram #(
    .Width (fcr_pkg::WeightW),
    .Depth (WD)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (value_i[fcr_pkg::WeightW-1:0]),
    .re_i    (mac_rd),
    .raddr_i (waddr_q),
    .rdata_o (w_rdata)
  );

  fcr_ram #(
    .Width (fcr_pkg::BiasW),
    .Depth (MAX_OUTPUTS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (value_i),
    .re_i    (bias_rd),
    .raddr_i (neuron_q[NW-1:0]),
    .rdata_o (b_rdata)
  );

  fcr_ram #(
    .Width (fcr_pkg::WeightW),
    .Depth (MAX_INPUTS)
  ) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (value_i[fcr_pkg::WeightW-1:0]),
    .re_i    (mac_rd),
    .raddr_i (elem_q[EW-1:0]),
    .rdata_o (x_rdata)
  );

  // sequencer: per neuron fetch bias, stream in_count weight/input pairs, drain, emit
  always_comb begin
    state_d  = state_q;
    neuron_d = neuron_q;
    nout_d   = nout_q;
    elem_d   = elem_q;
    nin_d    = nin_q;
    wbase_d  = wbase_q;
    waddr_d  = waddr_q;
    case (state_q)
      fcr_pkg::S_IDLE: begin
        if (in_xfer && (mode == fcr_pkg::MODE_COMPUTE)) begin
          nin_d    = nin_clamp;
          nout_d   = nout_clamp;
          neuron_d = '0;
          wbase_d  = '0;
          // zero neurons: nothing to emit
          if (nout_clamp != '0) begin
            state_d = fcr_pkg::S_BIAS;
          end
        end
      end
      fcr_pkg::S_BIAS: begin
        elem_d  = '0;
        waddr_d = wbase_q;
        // zero elements: result is just the bias
        state_d = (nin_q == '0) ? fcr_pkg::S_DRAIN : fcr_pkg::S_MAC;
      end
      fcr_pkg::S_MAC: begin
        elem_d  = elem_q + ECW'(1);
        waddr_d = waddr_q + WAW'(1);
        if ((elem_q + ECW'(1)) == nin_q) begin
          state_d = fcr_pkg::S_DRAIN;
        end
      end
      fcr_pkg::S_DRAIN: begin
        if (!bias_vld_q && !rd_vld_q && !prod_vld_q) begin
          state_d = fcr_pkg::S_DONE;
        end
      end
      fcr_pkg::S_DONE: begin
        if (out_load) begin
          if (run_last) begin
            state_d = fcr_pkg::S_IDLE;
          end else begin
            neuron_d = neuron_q + NCW'(1);
            wbase_d  = wbase_q + WAW'(MAX_INPUTS);
            state_d  = fcr_pkg::S_BIAS;
          end
        end
      end
      default: begin
        state_d = fcr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcr_pkg::S_IDLE;
      neuron_q    <= '0;
      nout_q      <= '0;
      elem_q      <= '0;
      nin_q       <= '0;
      wbase_q     <= '0;
      waddr_q     <= '0;
      bias_vld_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      neuron_q   <= neuron_d;
      nout_q     <= nout_d;
      elem_q     <= elem_d;
      nin_q      <= nin_d;
      wbase_q    <= wbase_d;
      waddr_q    <= waddr_d;
      bias_vld_q <= bias_rd;
      rd_vld_q   <= mac_rd;
      prod_vld_q <= rd_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared multiply-accumulate: multiply registered, then one wide add
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= $signed(w_rdata) * $signed(x_rdata);
    end
    if (bias_vld_q) begin
      acc_q <= AW'($signed(b_rdata));
    end else if (prod_vld_q) begin
      acc_q <= acc_q + AW'(prod_q);
    end
  end

  // relu floor at zero, saturate to 31 bits
  always_comb begin
    if (acc_q[AW-1]) begin
      act_sat = '0;
    end else if (|acc_q[AW-2:fcr_pkg::ActW]) begin
      act_sat = '1;
    end else begin
      act_sat = acc_q[fcr_pkg::ActW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_neuron_q <= fcr_pkg::NeuronW'(neuron_q);
      out_act_q    <= act_sat;
      out_last_q   <= run_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign neuron_o     = out_neuron_q;
  assign activation_o = out_act_q;
  assign last_o       = out_last_q;

  // bias load and product add never land on the same edge
  a_acc_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bias_vld_q && prod_vld_q))
    else $error("bias load collides with accumulate");

  // result is taken only once the pipeline is empty
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcr_pkg::S_DONE) |-> (!bias_vld_q && !rd_vld_q && !prod_vld_q))
    else $error("result stage reached with reads in flight");

  // element counter stays inside the run length
  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcr_pkg::S_MAC) |-> (elem_q < nin_q))
    else $error("element counter past in_count");

  // neuron counter stays inside the run while busy
  a_neuron_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fcr_pkg::S_IDLE) |-> (neuron_q < nout_q))
    else $error("neuron counter past out_count");

  // output register fills only from the result stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fcr_pkg::S_DONE))
    else $error("output valid without a finished neuron");

endmodule

`default_nettype wire
